FILE: sv/fbik_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, codes and the arctangent table for the five-bar leg
// inverse kinematics block. No dependencies.
package fbik_pkg;

  localparam int LEN_W      = 11;
  localparam int CRD_W      = 12;
  localparam int OFF_W      = 15;
  localparam int ANG_W      = 16;
  localparam int CFG_W      = 15;
  localparam int IDX_W      = 3;
  localparam int OPD_W      = 28;          // multiplier operand
  localparam int PRD_W      = 2 * OPD_W;   // product and discriminant accumulators
  localparam int R2_W       = 25;
  localparam int RAD_W      = 50;          // discriminant is below 2^49
  localparam int ROOT_W     = RAD_W / 2;
  localparam int ND_W       = 29;          // numerator / denominator
  localparam int CXY_W      = 45;          // CORDIC x/y
  localparam int Z_W        = 27;          // CORDIC angle, Q.24
  localparam int T_W        = 30;          // doubled angle
  localparam int ATAN_N     = 24;
  localparam int STEP_W     = 5;
  localparam int NORM_SHIFT = 40;
  localparam logic signed [T_W-1:0] TWO_PI_Q24 = T_W'(105414357);

  typedef struct packed {
    logic signed [CRD_W-1:0] target_x;
    logic signed [CRD_W-1:0] target_y;
  } in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] front_angle;
    logic signed [ANG_W-1:0] rear_angle;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic [LEN_W-1:0]        len_crank_front;
    logic [LEN_W-1:0]        len_upper_front;
    logic [LEN_W-1:0]        len_upper_rear;
    logic [LEN_W-1:0]        len_crank_rear;
    logic [LEN_W-1:0]        base_spacing;
    logic signed [OFF_W-1:0] front_offset;
    logic signed [OFF_W-1:0] rear_offset;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_SOLVED = 2'd0,
    ST_RANGE  = 2'd1,
    ST_NOSOL  = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LEN_CRANK_FRONT = 3'd0,
    REG_LEN_UPPER_FRONT = 3'd1,
    REG_LEN_UPPER_REAR  = 3'd2,
    REG_LEN_CRANK_REAR  = 3'd3,
    REG_BASE_SPACING    = 3'd4,
    REG_FRONT_OFFSET    = 3'd5,
    REG_REAR_OFFSET     = 3'd6
  } reg_idx_t;

  // multiplier operations, issued one per cycle
  typedef enum logic [4:0] {
    MOP_XX   = 5'd0,
    MOP_YY   = 5'd1,
    MOP_L1Y  = 5'd2,
    MOP_L1X  = 5'd3,
    MOP_L1L1 = 5'd4,
    MOP_L2L2 = 5'd5,
    MOP_L4Y  = 5'd6,
    MOP_L4XM = 5'd7,
    MOP_L3L3 = 5'd8,
    MOP_L5X  = 5'd9,
    MOP_L4L4 = 5'd10,
    MOP_L5L5 = 5'd11,
    MOP_PFPF = 5'd12,
    MOP_QFQF = 5'd13,
    MOP_RFRF = 5'd14,
    MOP_PRPR = 5'd15,
    MOP_QRQR = 5'd16,
    MOP_RRRR = 5'd17
  } mop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_DRN1,
    S_CHK1,
    S_MUL2,
    S_DRN2,
    S_CHK2,
    S_ROOT,
    S_ANG,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    mop_t mul_op;
    logic sqrt_start;
    logic cordic_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic nosol;
    logic sqrt_busy;
    logic cordic_busy;
  } sts_t;

  // atan(2^-i) in Q.24 radians
  function automatic logic [Z_W-1:0] atan_q24(input logic [STEP_W-1:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(13176795);
      5'd1:    v = Z_W'(7778716);
      5'd2:    v = Z_W'(4110060);
      5'd3:    v = Z_W'(2086331);
      5'd4:    v = Z_W'(1047214);
      5'd5:    v = Z_W'(524117);
      5'd6:    v = Z_W'(262123);
      5'd7:    v = Z_W'(131069);
      5'd8:    v = Z_W'(65536);
      5'd9:    v = Z_W'(32768);
      5'd10:   v = Z_W'(16384);
      5'd11:   v = Z_W'(8192);
      5'd12:   v = Z_W'(4096);
      5'd13:   v = Z_W'(2048);
      5'd14:   v = Z_W'(1024);
      5'd15:   v = Z_W'(512);
      5'd16:   v = Z_W'(256);
      5'd17:   v = Z_W'(128);
      5'd18:   v = Z_W'(64);
      5'd19:   v = Z_W'(32);
      5'd20:   v = Z_W'(16);
      5'd21:   v = Z_W'(8);
      5'd22:   v = Z_W'(4);
      5'd23:   v = Z_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/fbik_isqrt.sv
`timescale 1ns / 1ps
// Iterative floor integer square root, one result bit per cycle.
// Depends on fbik_pkg.
module fbik_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fbik_pkg::RAD_W-1:0]  radicand,
  output logic                        busy,
  output logic [fbik_pkg::ROOT_W-1:0] root
);

  localparam int RW  = fbik_pkg::ROOT_W;
  localparam int CNW = $clog2(RW);

  logic [fbik_pkg::RAD_W-1:0] rad;
  logic [RW+1:0]              rem;
  logic [CNW-1:0]             cnt;
  logic [RW+3:0]              rem_sh;
  logic [RW+3:0]              trial;

  assign rem_sh = {rem, rad[fbik_pkg::RAD_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= CNW'(RW - 1);
    end else if (busy) begin
      rad <= {rad[fbik_pkg::RAD_W-3:0], 2'b00};
      cnt <= cnt - 1'b1;
      if (rem_sh >= trial) begin
        rem  <= (RW+2)'(rem_sh - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RW+1:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/fbik_cordic.sv
`timescale 1ns / 1ps
// Vectoring CORDIC: normalizes (|den|, num*sign(den)) and returns atan(num/den)
// in Q.24 radians. Depends on fbik_pkg.
module fbik_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [fbik_pkg::ND_W-1:0] num,
  input  logic signed [fbik_pkg::ND_W-1:0] den,
  output logic                            busy,
  output logic signed [fbik_pkg::Z_W-1:0]  angle
);

  localparam int XW    = fbik_pkg::CXY_W;
  localparam int NSTEP = (STEPS > fbik_pkg::ATAN_N) ? fbik_pkg::ATAN_N : STEPS;
  localparam logic [XW-1:0] LIM_HI = XW'(1) << fbik_pkg::NORM_SHIFT;
  localparam logic [XW-1:0] LIM_LO = XW'(1) << (fbik_pkg::NORM_SHIFT - 8);

  logic signed [XW-1:0]            x, y;
  logic                            norm;
  logic [fbik_pkg::STEP_W-1:0]     i;
  logic signed [XW-1:0]            num_e, den_e, dx, dy;
  logic [XW-1:0]                   ax, ay, m;

  assign num_e = XW'(num);
  assign den_e = XW'(den);
  assign ax    = x[XW-1] ? XW'(-x) : XW'(x);
  assign ay    = y[XW-1] ? XW'(-y) : XW'(y);
  assign m     = (ax > ay) ? ax : ay;
  assign dx    = y >>> i;
  assign dy    = x >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && !norm && i == fbik_pkg::STEP_W'(NSTEP - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x     <= den_e[XW-1] ? -den_e : den_e;
      y     <= den_e[XW-1] ? -num_e : num_e;
      angle <= '0;
      i     <= '0;
      norm  <= 1'b1;
    end else if (busy) begin
      if (norm) begin
        // doubling until the larger magnitude reaches the limit, 8 at a time while safe
        if (m >= LIM_HI) begin
          norm <= 1'b0;
        end else if (m < LIM_LO) begin
          x <= x <<< 8;
          y <= y <<< 8;
        end else begin
          x <= x <<< 1;
          y <= y <<< 1;
        end
      end else begin
        i <= i + 1'b1;
        if (!y[XW-1]) begin
          x     <= x + dx;
          y     <= y - dy;
          angle <= angle + $signed(fbik_pkg::atan_q24(i));
        end else begin
          x     <= x - dx;
          y     <= y + dy;
          angle <= angle - $signed(fbik_pkg::atan_q24(i));
        end
      end
    end
  end

endmodule

FILE: sv/fbik_datapath.sv
`timescale 1ns / 1ps
// Datapath: shared multiplier with accumulators, square roots, CORDIC units,
// angle finishing, held angles and the output register. Depends on fbik_pkg.
module fbik_datapath #(
  parameter int unsigned MIN_RADIUS   = 800,
  parameter int unsigned MAX_RADIUS   = 1760,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  fbik_pkg::cfg_t  cfg,
  input  fbik_pkg::in_t   in_data,
  input  fbik_pkg::cmd_t  cmd,
  output fbik_pkg::sts_t  sts,
  output fbik_pkg::out_t  out_data
);

  localparam int OW = fbik_pkg::OPD_W;
  localparam int PW = fbik_pkg::PRD_W;
  localparam int NW = fbik_pkg::ND_W;
  localparam int TW = fbik_pkg::T_W;
  localparam int AW = fbik_pkg::ANG_W;
  localparam logic [fbik_pkg::R2_W-1:0] MIN_SQ = fbik_pkg::R2_W'(MIN_RADIUS * MIN_RADIUS);
  localparam logic [fbik_pkg::R2_W-1:0] MAX_SQ = fbik_pkg::R2_W'(MAX_RADIUS * MAX_RADIUS);
  localparam int ANG_MAX = 2 ** (AW - 1) - 1;
  localparam int ANG_MIN = -(2 ** (AW - 1));

  logic signed [fbik_pkg::CRD_W-1:0] x, y;
  logic signed [fbik_pkg::CRD_W:0]   xm;
  logic [fbik_pkg::R2_W-1:0]         r2;
  logic signed [OW-1:0]              pf, qf, rf, pr, qr, rr;
  logic signed [PW-1:0]              df, dr;
  logic signed [OW-1:0]              ma, mb;
  logic signed [PW-1:0]              prod;
  logic                              prod_vld;
  fbik_pkg::mop_t                    prod_op;
  logic signed [OW-1:0]              p1, p2;
  logic signed [OW-1:0]              l1, l2, l3, l4, l5;
  logic signed [NW-1:0]              den_f, den_r, num_f, num_r, rt_f, rt_r;
  logic [fbik_pkg::ROOT_W-1:0]       root_f, root_r;
  logic                              sq_busy_f, sq_busy_r, co_busy_f, co_busy_r;
  logic signed [fbik_pkg::Z_W-1:0]   z_f, z_r;
  logic signed [TW-1:0]              t_f2, t_f, t_r;
  logic signed [AW-1:0]              held_front, held_rear;
  logic signed [AW-1:0]              ang_f, ang_r;

  function automatic logic signed [AW-1:0] finish_angle(
    input logic signed [TW-1:0]             t,
    input logic signed [fbik_pkg::OFF_W-1:0] off
  );
    logic signed [TW-1:0] tq;
    logic signed [TW:0]   v;
    logic signed [AW-1:0] r;
    tq = (t + TW'(4096)) >>> 13;
    v  = (TW+1)'(tq) - (TW+1)'(off);
    if (v > (TW+1)'(ANG_MAX)) begin
      r = AW'(ANG_MAX);
    end else if (v < (TW+1)'(ANG_MIN)) begin
      r = AW'(ANG_MIN);
    end else begin
      r = v[AW-1:0];
    end
    return r;
  endfunction

  assign l1 = OW'(cfg.len_crank_front);
  assign l2 = OW'(cfg.len_upper_front);
  assign l3 = OW'(cfg.len_upper_rear);
  assign l4 = OW'(cfg.len_crank_rear);
  assign l5 = OW'(cfg.base_spacing);
  assign xm = (fbik_pkg::CRD_W+1)'(x) - $signed({2'b00, cfg.base_spacing});

  always_comb begin
    case (cmd.mul_op)
      fbik_pkg::MOP_XX:   begin ma = OW'(x);  mb = OW'(x);  end
      fbik_pkg::MOP_YY:   begin ma = OW'(y);  mb = OW'(y);  end
      fbik_pkg::MOP_L1Y:  begin ma = l1;      mb = OW'(y);  end
      fbik_pkg::MOP_L1X:  begin ma = l1;      mb = OW'(x);  end
      fbik_pkg::MOP_L1L1: begin ma = l1;      mb = l1;      end
      fbik_pkg::MOP_L2L2: begin ma = l2;      mb = l2;      end
      fbik_pkg::MOP_L4Y:  begin ma = l4;      mb = OW'(y);  end
      fbik_pkg::MOP_L4XM: begin ma = l4;      mb = OW'(xm); end
      fbik_pkg::MOP_L3L3: begin ma = l3;      mb = l3;      end
      fbik_pkg::MOP_L5X:  begin ma = l5;      mb = OW'(x);  end
      fbik_pkg::MOP_L4L4: begin ma = l4;      mb = l4;      end
      fbik_pkg::MOP_L5L5: begin ma = l5;      mb = l5;      end
      fbik_pkg::MOP_PFPF: begin ma = pf;      mb = pf;      end
      fbik_pkg::MOP_QFQF: begin ma = qf;      mb = qf;      end
      fbik_pkg::MOP_RFRF: begin ma = rf;      mb = rf;      end
      fbik_pkg::MOP_PRPR: begin ma = pr;      mb = pr;      end
      fbik_pkg::MOP_QRQR: begin ma = qr;      mb = qr;      end
      fbik_pkg::MOP_RRRR: begin ma = rr;      mb = rr;      end
      default:            begin ma = '0;      mb = '0;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= ma * mb;
    prod_op <= cmd.mul_op;
  end

  assign p1 = prod[OW-1:0];
  assign p2 = {prod[OW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x  <= in_data.target_x;
      y  <= in_data.target_y;
      r2 <= '0;
      rf <= '0;
      rr <= '0;
      df <= '0;
      dr <= '0;
    end else if (prod_vld) begin
      case (prod_op)
        fbik_pkg::MOP_XX, fbik_pkg::MOP_YY: begin
          r2 <= r2 + prod[fbik_pkg::R2_W-1:0];
          rf <= rf - p1;
          rr <= rr - p1;
        end
        fbik_pkg::MOP_L1Y:  pf <= p2;
        fbik_pkg::MOP_L1X:  qf <= p2;
        fbik_pkg::MOP_L1L1: rf <= rf - p1;
        fbik_pkg::MOP_L2L2: rf <= rf + p1;
        fbik_pkg::MOP_L4Y:  pr <= p2;
        fbik_pkg::MOP_L4XM: qr <= p2;
        fbik_pkg::MOP_L3L3: rr <= rr + p1;
        fbik_pkg::MOP_L5X:  rr <= rr + p2;
        fbik_pkg::MOP_L4L4, fbik_pkg::MOP_L5L5: rr <= rr - p1;
        fbik_pkg::MOP_PFPF, fbik_pkg::MOP_QFQF: df <= df + prod;
        fbik_pkg::MOP_RFRF: df <= df - prod;
        fbik_pkg::MOP_PRPR, fbik_pkg::MOP_QRQR: dr <= dr + prod;
        fbik_pkg::MOP_RRRR: dr <= dr - prod;
        default: ;
      endcase
    end
  end

  assign den_f = NW'(qf) - NW'(rf);
  assign den_r = NW'(qr) - NW'(rr);

  assign sts.range_bad   = (r2 > MAX_SQ) || (r2 < MIN_SQ);
  assign sts.nosol       = df[PW-1] || dr[PW-1] || den_f == '0 || den_r == '0;
  assign sts.sqrt_busy   = sq_busy_f || sq_busy_r;
  assign sts.cordic_busy = co_busy_f || co_busy_r;

  fbik_isqrt u_root_f (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (df[fbik_pkg::RAD_W-1:0]),
    .busy     (sq_busy_f),
    .root     (root_f)
  );

  fbik_isqrt u_root_r (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (dr[fbik_pkg::RAD_W-1:0]),
    .busy     (sq_busy_r),
    .root     (root_r)
  );

  assign rt_f  = NW'(root_f);
  assign rt_r  = NW'(root_r);
  assign num_f = NW'(pf) + rt_f;
  assign num_r = NW'(pr) - rt_r;

  fbik_cordic #(.STEPS(CORDIC_STEPS)) u_atan_f (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cordic_start),
    .num   (num_f),
    .den   (den_f),
    .busy  (co_busy_f),
    .angle (z_f)
  );

  fbik_cordic #(.STEPS(CORDIC_STEPS)) u_atan_r (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.cordic_start),
    .num   (num_r),
    .den   (den_r),
    .busy  (co_busy_r),
    .angle (z_r)
  );

  // front angle wraps into [0, 2pi)
  assign t_f2  = TW'(z_f) <<< 1;
  assign t_f   = t_f2[TW-1] ? t_f2 + fbik_pkg::TWO_PI_Q24 : t_f2;
  assign t_r   = TW'(z_r) <<< 1;
  assign ang_f = finish_angle(t_f, cfg.front_offset);
  assign ang_r = finish_angle(t_r, cfg.rear_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_front <= '0;
      held_rear  <= '0;
    end else if (cmd.finish && !sts.range_bad && !sts.nosol) begin
      held_front <= ang_f;
      held_rear  <= ang_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sts.range_bad) begin
        out_data <= {held_front, held_rear, fbik_pkg::ST_RANGE};
      end else if (sts.nosol) begin
        out_data <= {held_front, held_rear, fbik_pkg::ST_NOSOL};
      end else begin
        out_data <= {ang_f, ang_r, fbik_pkg::ST_SOLVED};
      end
    end
  end

endmodule

FILE: sv/fbik_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences multiplies, checks, square roots, CORDIC and the
// output handshake. Depends on fbik_pkg.
module fbik_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  fbik_pkg::sts_t  sts,
  output fbik_pkg::cmd_t  cmd
);

  fbik_pkg::state_t state, state_next;
  fbik_pkg::mop_t   op, op_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbik_pkg::S_IDLE;
      op        <= fbik_pkg::MOP_XX;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.mul_op     = op;
    out_valid_next = out_valid && !out_ready;
    case (state)
      fbik_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          op_next    = fbik_pkg::MOP_XX;
          state_next = fbik_pkg::S_MUL1;
        end
      end
      fbik_pkg::S_MUL1: begin
        cmd.mul_en = 1'b1;
        if (op == fbik_pkg::MOP_L5L5) begin
          state_next = fbik_pkg::S_DRN1;
        end else begin
          op_next = fbik_pkg::mop_t'(op + 1'b1);
        end
      end
      fbik_pkg::S_DRN1: state_next = fbik_pkg::S_CHK1;
      fbik_pkg::S_CHK1: begin
        if (sts.range_bad) begin
          state_next = fbik_pkg::S_FIN;
        end else begin
          op_next    = fbik_pkg::MOP_PFPF;
          state_next = fbik_pkg::S_MUL2;
        end
      end
      fbik_pkg::S_MUL2: begin
        cmd.mul_en = 1'b1;
        if (op == fbik_pkg::MOP_RRRR) begin
          state_next = fbik_pkg::S_DRN2;
        end else begin
          op_next = fbik_pkg::mop_t'(op + 1'b1);
        end
      end
      fbik_pkg::S_DRN2: state_next = fbik_pkg::S_CHK2;
      fbik_pkg::S_CHK2: begin
        if (sts.nosol) begin
          state_next = fbik_pkg::S_FIN;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_next     = fbik_pkg::S_ROOT;
        end
      end
      fbik_pkg::S_ROOT: begin
        if (!sts.sqrt_busy) begin
          cmd.cordic_start = 1'b1;
          state_next       = fbik_pkg::S_ANG;
        end
      end
      fbik_pkg::S_ANG: begin
        if (!sts.cordic_busy) begin
          state_next = fbik_pkg::S_FIN;
        end
      end
      fbik_pkg::S_FIN: begin
        // the previous item must have left the output register
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = fbik_pkg::S_IDLE;
        end
      end
      default: state_next = fbik_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: sv/five_bar_leg_inverse_kinematics_top.sv
`timescale 1ns / 1ps
// Five-bar leg inverse kinematics, top level: configuration registers,
// controller and datapath. Depends on fbik_pkg, fbik_ctrl, fbik_datapath.
//
// Usage:
//   in_valid/in_ready carry one target item (target_x, target_y, 1/16 mm).
//   out_valid/out_ready carry one result item: front and rear angles in
//   signed Q5.11 radians and a status (solved, outside radius annulus,
//   no real solution). Unsolved items repeat the last solved angles.
//   The config port (cfg_we, cfg_index, cfg_data) writes the link lengths
//   and angle offsets; write only while no item is in flight.
//   A solved item passes through 18 issues on one shared 28x28 multiplier,
//   a bit-serial square root (both branches in parallel), a normalize
//   step and CORDIC_STEPS vectoring iterations. An item outside the
//   annulus skips the second multiply pass, the square root and CORDIC;
//   one with no real solution skips the square root and CORDIC. One item is
//   worked on at a time; the next is accepted as soon as the result is in
//   the output register.
//   If the receiver stalls, the result waits in the output register and a
//   following item is processed up to its last step, then waits.
//   Reset (rst, synchronous) restores the register defaults, clears the
//   held angles to zero and empties the block.
module five_bar_leg_inverse_kinematics_top #(
  parameter int unsigned MIN_RADIUS   = 800,
  parameter int unsigned MAX_RADIUS   = 1760,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fbik_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fbik_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [fbik_pkg::IDX_W-1:0]  cfg_index,
  input  logic [fbik_pkg::CFG_W-1:0]  cfg_data
);

  fbik_pkg::cfg_t cfg;
  fbik_pkg::cmd_t cmd;
  fbik_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.len_crank_front <= fbik_pkg::LEN_W'(800);
      cfg.len_upper_front <= fbik_pkg::LEN_W'(1280);
      cfg.len_upper_rear  <= fbik_pkg::LEN_W'(1280);
      cfg.len_crank_rear  <= fbik_pkg::LEN_W'(800);
      cfg.base_spacing    <= fbik_pkg::LEN_W'(352);
      cfg.front_offset    <= fbik_pkg::OFF_W'(6434);
      cfg.rear_offset     <= '0;
    end else if (cfg_we) begin
      case (fbik_pkg::reg_idx_t'(cfg_index))
        fbik_pkg::REG_LEN_CRANK_FRONT: cfg.len_crank_front <= cfg_data[fbik_pkg::LEN_W-1:0];
        fbik_pkg::REG_LEN_UPPER_FRONT: cfg.len_upper_front <= cfg_data[fbik_pkg::LEN_W-1:0];
        fbik_pkg::REG_LEN_UPPER_REAR:  cfg.len_upper_rear  <= cfg_data[fbik_pkg::LEN_W-1:0];
        fbik_pkg::REG_LEN_CRANK_REAR:  cfg.len_crank_rear  <= cfg_data[fbik_pkg::LEN_W-1:0];
        fbik_pkg::REG_BASE_SPACING:    cfg.base_spacing    <= cfg_data[fbik_pkg::LEN_W-1:0];
        fbik_pkg::REG_FRONT_OFFSET:    cfg.front_offset    <= cfg_data;
        fbik_pkg::REG_REAR_OFFSET:     cfg.rear_offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  fbik_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbik_datapath #(
    .MIN_RADIUS   (MIN_RADIUS),
    .MAX_RADIUS   (MAX_RADIUS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accepted item");

  // a new result only comes at the end of work on an item
  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result appeared without an item in progress");

  // the output register is only reloaded once the previous item has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !cmd.finish)
    else $error("result overwritten before it was taken");
`endif

endmodule
